// ===== design/sid_pkg.sv =====
package sid_pkg;

  // Width of the binary magnitude and of the BCD accumulator.
  localparam int MAG_W  = 64;
  localparam int DIGITS = 20;
  localparam int BCD_W  = 4 * DIGITS;
  localparam int CNT_W  = $clog2(MAG_W);
  localparam int LEN_W  = 5;

  // ASCII codes used in the text.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_NONE  = 8'h00;

  // Commands from the sequencer to the BCD shift register.
  typedef struct packed {
    logic load;
    logic dabble;
    logic shift_digit;
  } bcd_ctrl_t;

endpackage

// ===== design/signed_int_to_decimal_ascii.sv =====
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_ready     in_value, in_buffer_size
// out      output     out_valid / out_ready   out_character, out_position, out_is_last,
//                                             out_text_length, out_fits
//
// Each transaction emits the characters of its text, or a single result when the
// text does not fit.
// Most of a transaction is spent in the 64 steps of the double-dabble shift register.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_valid.
// A stalled output holds its transaction; the sequencer waits until the slot frees.
module signed_int_to_decimal_ascii (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [63:0]        in_value,
  input  logic [7:0]                in_buffer_size,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_character,
  output logic [sid_pkg::LEN_W-1:0] out_position,
  output logic                      out_is_last,
  output logic [sid_pkg::LEN_W-1:0] out_text_length,
  output logic                      out_fits
);
  import sid_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DABBLE, S_NORM, S_EMIT} state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;
  logic [7:0]       cap_r, cap_nxt;
  logic [LEN_W-1:0] ndig_r, ndig_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic             fits_r, fits_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  logic [LEN_W-1:0] out_pos_r, out_pos_nxt;
  logic             out_last_r, out_last_nxt;
  logic [LEN_W-1:0] out_len_r, out_len_nxt;
  logic             out_fits_r, out_fits_nxt;

  bcd_ctrl_t        ctrl;
  logic [MAG_W-1:0] load_mag;
  logic [3:0]       top_digit;
  logic [LEN_W-1:0] len_sum;
  logic             last_char;

  // Magnitude as an unsigned number, so the most negative value converts too.
  assign load_mag = in_value[63] ? (~in_value + 64'd1) : in_value;

  sid_bcd u_bcd (
    .clk       (clk),
    .ctrl      (ctrl),
    .load_mag  (load_mag),
    .top_digit (top_digit)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign len_sum   = ndig_r + {{(LEN_W-1){1'b0}}, neg_r};
  assign last_char = (pos_r + 5'd1) == len_r;

  // Sequencer: load, dabble, strip leading zeros, then emit characters.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    cap_nxt       = cap_r;
    ndig_nxt      = ndig_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    fits_nxt      = fits_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;
    out_len_nxt   = out_len_r;
    out_fits_nxt  = out_fits_r;
    ctrl          = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.load = 1'b1;
          neg_nxt   = in_value[63];
          cap_nxt   = in_buffer_size;
          cnt_nxt   = '0;
          ndig_nxt  = LEN_W'(DIGITS);
          state_nxt = S_DABBLE;
        end
      end
      S_DABBLE: begin
        ctrl.dabble = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MAG_W - 1)) begin
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        // Zero keeps one digit; otherwise drop leading zero digits.
        if (top_digit == 4'd0 && ndig_r > 5'd1) begin
          ctrl.shift_digit = 1'b1;
          ndig_nxt         = ndig_r - 5'd1;
        end else begin
          len_nxt   = len_sum;
          fits_nxt  = {3'd0, len_sum} < cap_r;
          pos_nxt   = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (!fits_r) begin
            out_char_nxt = CHAR_NONE;
            out_pos_nxt  = '0;
            out_last_nxt = 1'b1;
            out_len_nxt  = '0;
            out_fits_nxt = 1'b0;
            state_nxt    = S_IDLE;
          end else begin
            if (neg_r && pos_r == 5'd0) begin
              out_char_nxt = CHAR_MINUS;
            end else begin
              out_char_nxt     = CHAR_ZERO | {4'd0, top_digit};
              ctrl.shift_digit = 1'b1;
            end
            out_pos_nxt  = pos_r;
            out_last_nxt = last_char;
            out_len_nxt  = len_r;
            out_fits_nxt = 1'b1;
            pos_nxt      = pos_r + 5'd1;
            if (last_char) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    cap_r      <= cap_nxt;
    ndig_r     <= ndig_nxt;
    len_r      <= len_nxt;
    pos_r      <= pos_nxt;
    fits_r     <= fits_nxt;
    out_char_r <= out_char_nxt;
    out_pos_r  <= out_pos_nxt;
    out_last_r <= out_last_nxt;
    out_len_r  <= out_len_nxt;
    out_fits_r <= out_fits_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_character   = out_char_r;
  assign out_position    = out_pos_r;
  assign out_is_last     = out_last_r;
  assign out_text_length = out_len_r;
  assign out_fits        = out_fits_r;

  // A text that fits never places a character past its own length.
  a_pos_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fits |-> out_position < out_text_length)
    else $error("character position beyond text length");

  // The last character of a fitting text sits at the final position.
  a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fits && out_is_last |-> (out_position + 5'd1) == out_text_length)
    else $error("last flag not on final position");

  // A text that does not fit gives one empty result.
  a_no_fit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fits |->
      out_character == CHAR_NONE && out_text_length == 5'd0 && out_is_last)
    else $error("malformed not-fitting result");

  // Past the first place only decimal digits appear.
  a_digit_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fits && out_position != 5'd0 |->
      out_character >= CHAR_ZERO && out_character <= 8'h39)
    else $error("non-digit character after first position");

endmodule

// ===== design/sid_bcd.sv =====
module sid_bcd (
  input  logic                      clk,
  input  sid_pkg::bcd_ctrl_t        ctrl,
  input  logic [sid_pkg::MAG_W-1:0] load_mag,
  output logic [3:0]                top_digit
);
  import sid_pkg::*;

  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [BCD_W-1:0] adj;

  // Add three to every BCD digit of five or more before the next doubling.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  // One binary bit moves into the BCD register per dabble step; digit shifts
  // bring the next decimal digit to the top.
  always_comb begin
    mag_nxt = mag_r;
    bcd_nxt = bcd_r;
    if (ctrl.load) begin
      mag_nxt = load_mag;
      bcd_nxt = '0;
    end else if (ctrl.dabble) begin
      bcd_nxt = {adj[BCD_W-2:0], mag_r[MAG_W-1]};
      mag_nxt = {mag_r[MAG_W-2:0], 1'b0};
    end else if (ctrl.shift_digit) begin
      bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

  assign top_digit = bcd_r[BCD_W-1 -: 4];

endmodule

// ===== tb/decimal_text_checker.sv =====
// Watches both channels of the integer-to-text converter, predicts the
// characters of each accepted value and compares every accepted result.
module decimal_text_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [63:0]        in_value,
  input  logic [7:0]                in_buffer_size,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [7:0]                out_character,
  input  logic [sid_pkg::LEN_W-1:0] out_position,
  input  logic                      out_is_last,
  input  logic [sid_pkg::LEN_W-1:0] out_text_length,
  input  logic                      out_fits,
  output int                        mismatches,
  output int                        pending,
  output int                        chars_checked,
  output int                        overflows_checked
);
  import sid_pkg::*;

  // One character of converted text, laid out like the result channel.
  typedef struct packed {
    logic [7:0]       character;
    logic [LEN_W-1:0] position;
    logic             is_last;
    logic [LEN_W-1:0] text_length;
    logic             fits;
  } text_char_t;

  text_char_t expected_text[$];

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input longint unsigned want_v,
                                 input longint unsigned got_v);
    $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want_v, got_v);
    mismatches++;
  endtask

  // Builds the decimal text of a value, or the single overflow marker when the
  // text and its terminator would not fit the buffer.
  function automatic void predict_decimal_text(input logic [63:0] raw,
                                               input logic [7:0] buf_size);
    logic [63:0] magnitude;
    logic [7:0]  digit_chars[DIGITS];
    int unsigned ndig;
    int unsigned text_len;
    bit          negative;
    text_char_t  item;
    negative  = raw[63];
    magnitude = negative ? (~raw + 64'd1) : raw;
    ndig      = 0;
    // Digits come out least significant first.
    do begin
      digit_chars[ndig] = CHAR_ZERO + 8'(magnitude % 64'd10);
      magnitude = magnitude / 64'd10;
      ndig++;
    end while (magnitude != 64'd0 && ndig < DIGITS);
    text_len = ndig + (negative ? 1 : 0);
    if (text_len >= buf_size) begin
      item = '{character: CHAR_NONE, position: '0, is_last: 1'b1,
               text_length: '0, fits: 1'b0};
      expected_text.push_back(item);
    end else begin
      for (int unsigned k = 0; k < text_len; k++) begin
        item.character   = (negative && k == 0) ? CHAR_MINUS
                                                : digit_chars[text_len - 1 - k];
        item.position    = LEN_W'(k);
        item.is_last     = (k + 1 == text_len);
        item.text_length = LEN_W'(text_len);
        item.fits        = 1'b1;
        expected_text.push_back(item);
      end
    end
  endfunction

  // Both channels are sampled at the rising edge, before the edge's updates land.
  // The counters clear while reset is held.
  always @(posedge clk) begin
    text_char_t want;
    if (!rst_n) begin
      mismatches        = 0;
      pending           = 0;
      chars_checked     = 0;
      overflows_checked = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_decimal_text(in_value, in_buffer_size);
      end
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          report_mismatch("result with no transaction pending", 0, out_character);
        end else begin
          want = expected_text.pop_front();
          if (out_character !== want.character)
            report_mismatch("character", want.character, out_character);
          if (out_position !== want.position)
            report_mismatch("position", want.position, out_position);
          if (out_is_last !== want.is_last)
            report_mismatch("is_last", want.is_last, out_is_last);
          if (out_text_length !== want.text_length)
            report_mismatch("text_length", want.text_length, out_text_length);
          if (out_fits !== want.fits)
            report_mismatch("fits", want.fits, out_fits);
          if (want.fits) chars_checked++;
          else overflows_checked++;
        end
      end
      pending = expected_text.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// Stimulus and verdict for the integer-to-text converter; checking is done by
// the checker instance beside the block.
module tb;
  import sid_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int RANDOM_ITEMS = 206;
  localparam int HOLD_CYCLES  = 400;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [63:0] in_value;
  logic [7:0]         in_buffer_size;
  logic               out_valid;
  logic               out_ready;
  logic [7:0]         out_character;
  logic [LEN_W-1:0]   out_position;
  logic               out_is_last;
  logic [LEN_W-1:0]   out_text_length;
  logic               out_fits;

  int mismatches;
  int pending;
  int chars_checked;
  int overflows_checked;
  int items_sent;
  bit idle_on;

  signed_int_to_decimal_ascii dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_value        (in_value),
    .in_buffer_size  (in_buffer_size),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_character   (out_character),
    .out_position    (out_position),
    .out_is_last     (out_is_last),
    .out_text_length (out_text_length),
    .out_fits        (out_fits)
  );

  decimal_text_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_value          (in_value),
    .in_buffer_size    (in_buffer_size),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_character     (out_character),
    .out_position      (out_position),
    .out_is_last       (out_is_last),
    .out_text_length   (out_text_length),
    .out_fits          (out_fits),
    .mismatches        (mismatches),
    .pending           (pending),
    .chars_checked     (chars_checked),
    .overflows_checked (overflows_checked)
  );

  // Clock with a period of 4.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offers one value, with random idle cycles ahead of it, and waits for acceptance.
  task automatic send_value(input logic [63:0] value, input logic [7:0] buf_size);
    while (idle_on && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_value       <= value;
    in_buffer_size <= buf_size;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Random magnitude of any digit count, either sign, and a buffer size that
  // mostly sits near the text lengths so both outcomes are common.
  task automatic send_random_value();
    logic [63:0] value;
    logic [7:0]  buf_size;
    value = {$urandom, $urandom};
    if ($urandom_range(3) != 0) value = value >> $urandom_range(63, 0);
    if ($urandom_range(1) != 0) value = -value;
    if ($urandom_range(9) < 6) buf_size = 8'($urandom_range(24, 0));
    else buf_size = 8'($urandom_range(255, 0));
    send_value(value, buf_size);
  endtask

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && items_sent >= 60) begin
        out_ready <= 1'b0;
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        out_ready <= !(idle_on && $urandom_range(99) < 11);
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("tb failed");
    $finish;
  end

  // Reset, directed corner cases, random values, drain and verdict.
  initial begin
    items_sent     = 0;
    idle_on        = 1'b1;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_value       <= '0;
    in_buffer_size <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Zero against a large buffer and tiny ones, including an empty one; then small positives.
    send_value(64'd0, 8'd255);
    send_value(64'd0, 8'd0);
    send_value(64'd0, 8'd1);
    send_value(64'd0, 8'd2);
    send_value(64'd1, 8'd2);
    send_value(64'd9, 8'd8);
    send_value(64'd10, 8'd3);
    // Small negatives right at the fit boundary.
    send_value(-64'sd1, 8'd3);
    send_value(-64'sd1, 8'd2);
    send_value(-64'sd10, 8'd4);
    // Digit count rollovers.
    send_value(64'd99, 8'd255);
    send_value(64'd100, 8'd255);
    send_value(64'd999999999999, 8'd13);
    send_value(64'd1000000000000, 8'd13);
    send_value(-64'sd1000000000000, 8'd15);
    send_value(64'd1000000000000000000, 8'd255);
    // Largest positive value around its 19-character length.
    send_value(64'h7FFF_FFFF_FFFF_FFFF, 8'd20);
    send_value(64'h7FFF_FFFF_FFFF_FFFF, 8'd19);
    send_value(64'h7FFF_FFFF_FFFF_FFFF, 8'd0);
    // Most negative value goes through its unsigned magnitude.
    send_value(64'h8000_0000_0000_0000, 8'd255);
    send_value(64'h8000_0000_0000_0000, 8'd21);
    send_value(64'h8000_0000_0000_0000, 8'd20);
    send_value(64'h8000_0000_0000_0001, 8'd255);
    send_value(-64'sd123456789, 8'd200);

    // Random values: idling, then a stretch with none, then idling again.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 100) idle_on = 1'b0;
      if (n == 160) idle_on = 1'b1;
      send_random_value();
    end
    in_valid <= 1'b0;

    // The wait on the clock lets the checker count the last transaction before draining.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("Converted %0d values, directed extremes plus random values of every length.",
             items_sent);
    $display("Checked %0d text characters and %0d buffer overflows.",
             chars_checked, overflows_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
